// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, switched off while reset is held.
`define CHK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("check failed");

// Implication from one condition to another in the following cycle.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== design/baro_pkg.sv =====
`timescale 1ns / 1ps

package baro_pkg;

    localparam int unsigned AddrW = 5;
    localparam int unsigned DataW = 32;
    localparam int unsigned RawW  = 24;
    localparam int unsigned ValW  = 19;

    localparam logic [1:0] REG_CAL_A = 2'd0;
    localparam logic [1:0] REG_CAL_B = 2'd1;
    localparam logic [1:0] REG_CAL_C = 2'd2;
    localparam logic [1:0] REG_OSS   = 2'd3;

    localparam logic [DataW-1:0] C_B6_OFS   = 32'd4000;
    localparam logic [DataW-1:0] C_X3_OFS   = 32'd32768;
    localparam logic [DataW-1:0] C_P_K1     = 32'd3038;
    localparam logic [DataW-1:0] C_P_K2     = 32'hFFFF_E343; // -7357
    localparam logic [DataW-1:0] C_P_K3     = 32'd3791;
    localparam logic [DataW-1:0] C_MSB      = 32'h8000_0000;
    localparam logic signed [DataW-1:0] C_LO     = -32'sd32768;
    localparam logic signed [DataW-1:0] C_T_HI   = 32'sd32767;
    localparam logic signed [DataW-1:0] C_P_HI   = 32'sd262143;

    typedef enum logic [5:0] {
        S_IDLE, S_T_MUL, S_T_X1, S_T_DSET, S_DIV, S_T_Q, S_T_OUT,
        S_P_B6, S_P_M1, S_P_B12, S_P_M2, S_P_X1A, S_P_M3, S_P_X2A,
        S_P_B3, S_P_B3R, S_P_M4, S_P_X1B, S_P_M5, S_P_X2B, S_P_X3,
        S_P_M6, S_P_B4, S_P_M7, S_P_DSET, S_P_Q, S_P_T, S_P_M9,
        S_P_M10, S_P_X1C, S_P_M11, S_P_X2C, S_P_SUM, S_P_OUT
    } state_t;

    // 50000 >> oss
    function automatic logic [DataW-1:0] oss_scale(input logic [1:0] oss);
        logic [DataW-1:0] r;
        case (oss)
            2'd0:    r = 32'd50000;
            2'd1:    r = 32'd25000;
            2'd2:    r = 32'd12500;
            2'd3:    r = 32'd6250;
            default: r = 32'd50000;
        endcase
        return r;
    endfunction

    function automatic logic [DataW-1:0] sext16(input logic [15:0] f);
        return {{16{f[15]}}, f};
    endfunction

    function automatic logic [DataW-1:0] sat32(input logic [DataW-1:0] v,
                                               input logic signed [DataW-1:0] hi);
        logic [DataW-1:0] r;
        if ($signed(v) < C_LO) begin
            r = C_LO;
        end else if ($signed(v) > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake          | Payload
// input     | s_valid / s_ready  | s_cmd, s_raw_sample
// result    | m_valid / m_ready  | m_kind, m_value, m_div_fault
// config    | APB, 64-bit data   | cal_word_a/b/c, oversampling at 8*i
//
// Temperature and pressure beats both use the one shared 32x32 multiplier and,
// unless the divisor is zero, the 32-step restoring divider.
// s_ready is high only while the sequencer is idle; a finished result is held
// in the output register, and the sequencer waits in its last step only while
// an earlier result has not yet been taken. Reset is synchronous and clears the
// calibration registers and the stored B5 term.
`include "assert_macros.svh"

module baro_temp_pressure_compensation (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [baro_pkg::RawW-1:0]     s_raw_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic signed [baro_pkg::ValW-1:0] m_value,
    output logic                          m_div_fault,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [baro_pkg::AddrW-1:0]    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import baro_pkg::*;

    logic [63:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;
    logic [31:0] temp_term_reg;

    state_t state_reg, state_next;
    logic        cmd_reg;
    logic [RawW-1:0] raw_reg;
    logic        fault_reg, neg_reg, big_reg;
    logic [31:0] prod_reg, x1_reg, x2_reg, x3_reg, b3_reg, b4_reg, b6_reg, b12_reg;
    logic [31:0] p_reg, rem_reg, quo_reg, dsr_reg;
    logic [4:0]  cnt_reg;
    logic        m_valid_reg, m_kind_reg, m_fault_reg;
    logic [ValW-1:0] m_value_reg;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
    logic [31:0] up, den, num, t_sum, p_sum;
    logic [32:0] rem_sh, diff;
    logic        cfg_wr, out_free;

    assign ac1 = sext16(cal_a_reg[15:0]);
    assign ac2 = sext16(cal_a_reg[31:16]);
    assign ac3 = sext16(cal_a_reg[47:32]);
    assign ac4 = {16'd0, cal_a_reg[63:48]};
    assign ac5 = {16'd0, cal_b_reg[15:0]};
    assign ac6 = {16'd0, cal_b_reg[31:16]};
    assign mc  = sext16(cal_b_reg[47:32]);
    assign md  = sext16(cal_b_reg[63:48]);
    assign b1  = sext16(cal_c_reg[15:0]);
    assign b2  = sext16(cal_c_reg[31:16]);

    assign up  = {8'd0, raw_reg >> (4'd8 - {2'd0, oss_reg})};
    assign den = x1_reg + md;
    assign num = mc << 11;
    assign t_sum = 32'($signed(b3_reg + 32'd8) >>> 4);
    assign p_sum = p_reg + 32'($signed(x1_reg + x2_reg + C_P_K3) >>> 4);

    // Shared multiplier: the low 32 bits equal the wrapped signed product.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_T_MUL: begin mul_a = {16'd0, raw_reg[15:0]} - ac6; mul_b = ac5; end
            S_P_M1:  begin mul_a = b6_reg;  mul_b = b6_reg; end
            S_P_M2:  begin mul_a = b12_reg; mul_b = b2; end
            S_P_M3:  begin mul_a = ac2;     mul_b = b6_reg; end
            S_P_M4:  begin mul_a = ac3;     mul_b = b6_reg; end
            S_P_M5:  begin mul_a = b12_reg; mul_b = b1; end
            S_P_M6:  begin mul_a = x3_reg + C_X3_OFS; mul_b = ac4; end
            S_P_M7:  begin mul_a = up - b3_reg; mul_b = oss_scale(oss_reg); end
            S_P_M9:  begin mul_a = x1_reg;  mul_b = x1_reg; end
            S_P_M10: begin mul_a = prod_reg; mul_b = C_P_K1; end
            S_P_M11: begin mul_a = C_P_K2;  mul_b = p_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // One restoring divide step per cycle.
    assign rem_sh = {rem_reg, quo_reg[31]};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) begin state_next = s_cmd ? S_P_B6 : S_T_MUL; end
            S_T_MUL:  state_next = S_T_X1;
            S_T_X1:   state_next = S_T_DSET;
            S_T_DSET: state_next = (den == '0) ? S_T_OUT : S_DIV;
            S_DIV:    if (cnt_reg == 5'd31) begin state_next = cmd_reg ? S_P_Q : S_T_Q; end
            S_T_Q:    state_next = S_T_OUT;
            S_T_OUT:  if (out_free) begin state_next = S_IDLE; end
            S_P_B6:   state_next = S_P_M1;
            S_P_M1:   state_next = S_P_B12;
            S_P_B12:  state_next = S_P_M2;
            S_P_M2:   state_next = S_P_X1A;
            S_P_X1A:  state_next = S_P_M3;
            S_P_M3:   state_next = S_P_X2A;
            S_P_X2A:  state_next = S_P_B3;
            S_P_B3:   state_next = S_P_B3R;
            S_P_B3R:  state_next = S_P_M4;
            S_P_M4:   state_next = S_P_X1B;
            S_P_X1B:  state_next = S_P_M5;
            S_P_M5:   state_next = S_P_X2B;
            S_P_X2B:  state_next = S_P_X3;
            S_P_X3:   state_next = S_P_M6;
            S_P_M6:   state_next = S_P_B4;
            S_P_B4:   state_next = S_P_M7;
            S_P_M7:   state_next = S_P_DSET;
            S_P_DSET: state_next = (b4_reg == '0) ? S_P_OUT : S_DIV;
            S_P_Q:    state_next = S_P_T;
            S_P_T:    state_next = S_P_M9;
            S_P_M9:   state_next = S_P_M10;
            S_P_M10:  state_next = S_P_X1C;
            S_P_X1C:  state_next = S_P_M11;
            S_P_M11:  state_next = S_P_X2C;
            S_P_X2C:  state_next = S_P_SUM;
            S_P_SUM:  state_next = S_P_OUT;
            S_P_OUT:  if (out_free) begin state_next = S_IDLE; end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                cmd_reg   <= s_cmd;
                raw_reg   <= s_raw_sample;
                fault_reg <= 1'b0;
            end
            S_T_MUL, S_P_M1, S_P_M2, S_P_M3, S_P_M4, S_P_M5, S_P_M6, S_P_M7,
            S_P_M9, S_P_M10, S_P_M11: prod_reg <= mul_p;
            S_T_X1:  x1_reg <= 32'($signed(prod_reg) >>> 15);
            S_T_DSET: begin
                fault_reg <= (den == '0);
                neg_reg   <= num[31] ^ den[31];
                rem_reg   <= '0;
                quo_reg   <= num[31] ? 32'd0 - num : num;
                dsr_reg   <= den[31] ? 32'd0 - den : den;
            end
            S_DIV: begin
                if (!diff[32]) begin
                    rem_reg <= diff[31:0];
                end else begin
                    rem_reg <= rem_sh[31:0];
                end
                quo_reg <= {quo_reg[30:0], !diff[32]};
            end
            // The B5 term is parked in b3_reg until the result is issued.
            S_T_Q:   b3_reg  <= x1_reg + (neg_reg ? 32'd0 - quo_reg : quo_reg);
            S_P_B6:  b6_reg  <= temp_term_reg - C_B6_OFS;
            S_P_B12: b12_reg <= 32'($signed(prod_reg) >>> 12);
            S_P_X1A: x1_reg  <= 32'($signed(prod_reg) >>> 11);
            S_P_X2A: x2_reg  <= 32'($signed(prod_reg) >>> 11);
            S_P_B3:  b3_reg  <= ((ac1 << 2) + x1_reg + x2_reg) << oss_reg;
            S_P_B3R: b3_reg  <= 32'($signed(b3_reg + 32'd2) >>> 2);
            S_P_X1B: x1_reg  <= 32'($signed(prod_reg) >>> 13);
            S_P_X2B: x2_reg  <= 32'($signed(prod_reg) >>> 16);
            S_P_X3:  x3_reg  <= 32'($signed(x1_reg + x2_reg + 32'd2) >>> 2);
            S_P_B4:  b4_reg  <= prod_reg >> 15;
            S_P_DSET: begin
                // prod_reg holds B7 here.
                fault_reg <= (b4_reg == '0);
                big_reg   <= (prod_reg >= C_MSB);
                rem_reg   <= '0;
                quo_reg   <= (prod_reg >= C_MSB) ? prod_reg : prod_reg << 1;
                dsr_reg   <= b4_reg;
            end
            S_P_Q:   p_reg  <= big_reg ? quo_reg << 1 : quo_reg;
            S_P_T:   x1_reg <= 32'($signed(p_reg) >>> 8);
            S_P_X1C: x1_reg <= 32'($signed(prod_reg) >>> 16);
            S_P_X2C: x2_reg <= 32'($signed(prod_reg) >>> 16);
            S_P_SUM: p_reg  <= p_sum;
            default: ;
        endcase
    end

    // Control state: stored term, result register, divide counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_term_reg <= '0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            if ((state_reg == S_T_OUT || state_reg == S_P_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            cnt_reg <= (state_reg == S_DIV) ? cnt_reg + 5'd1 : 5'd0;
            if (state_reg == S_T_OUT && out_free) begin
                m_kind_reg  <= 1'b0;
                m_fault_reg <= fault_reg;
                m_value_reg <= fault_reg ? '0 : ValW'(sat32(t_sum, C_T_HI));
                if (!fault_reg) begin
                    temp_term_reg <= b3_reg;
                end
            end
            if (state_reg == S_P_OUT && out_free) begin
                m_kind_reg    <= 1'b1;
                m_fault_reg   <= fault_reg;
                m_value_reg   <= fault_reg ? '0 : ValW'(sat32(p_reg, C_P_HI));
                temp_term_reg <= '0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_value     = m_value_reg;
    assign m_div_fault = m_fault_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_CAL_A: cal_a_reg <= pwdata;
                REG_CAL_B: cal_b_reg <= pwdata;
                REG_CAL_C: cal_c_reg <= pwdata[31:0];
                REG_OSS:   oss_reg   <= pwdata[1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_CAL_A: prdata = cal_a_reg;
            REG_CAL_B: prdata = cal_b_reg;
            REG_CAL_C: prdata = {32'd0, cal_c_reg};
            REG_OSS:   prdata = {62'd0, oss_reg};
            default:   prdata = '0;
        endcase
    end

    `CHK_NEXT(a_busy_after_beat, s_valid && s_ready, !s_ready)
    `CHK_NEXT(a_term_cleared, state_reg == S_P_OUT && out_free, temp_term_reg == '0)
    `CHK_ALWAYS(a_result_source, $rose(m_valid_reg) |-> ($past(state_reg) == S_T_OUT || $past(state_reg) == S_P_OUT))
    `CHK_ALWAYS(a_cnt_idle, state_reg != S_DIV && $past(state_reg) != S_DIV |-> cnt_reg == '0)

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import baro_pkg::*;

    localparam logic CMD_TEMP = 1'b0;
    localparam logic CMD_PRES = 1'b1;
    localparam int   DRAIN_CYCLES = 80;

    typedef struct packed {
        logic          kind;
        logic [ValW-1:0] value;
        logic          fault;
    } reading_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    logic [RawW-1:0] s_raw_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_kind;
    logic signed [ValW-1:0] m_value;
    logic m_div_fault;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    // Shadow of the calibration registers and of the stored B5 term.
    logic [63:0] cal_a, cal_b;
    logic [31:0] cal_c;
    logic [1:0]  oss_sel;
    logic [31:0] b5_held;

    reading_t readings_due[$];
    int errors = 0;
    bit steady = 1'b0;   // no idling on either side while set
    int ready_hold = 0;

    baro_temp_pressure_compensation uut (.*);

    always #1 aclk = ~aclk;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        logic signed [31:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] f);
        return {{16{f[15]}}, f};
    endfunction

    function automatic logic [31:0] clamp(input logic [31:0] v, input int hi);
        int s;
        s = v;
        if (s < -32768) return -32768;
        if (s > hi) return hi;
        return v;
    endfunction

    function automatic reading_t compensate(input logic cmd, input logic [RawW-1:0] raw);
        reading_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
        logic [31:0] x1, x2, x3, num, den, b5, up, b6, b12, b3, b4, b7, p, v;
        longint q;
        ac1 = sx(cal_a[15:0]);  ac2 = sx(cal_a[31:16]);
        ac3 = sx(cal_a[47:32]); ac4 = {16'd0, cal_a[63:48]};
        ac5 = {16'd0, cal_b[15:0]}; ac6 = {16'd0, cal_b[31:16]};
        mc = sx(cal_b[47:32]);  md = sx(cal_b[63:48]);
        b1 = sx(cal_c[15:0]);   b2 = sx(cal_c[31:16]);
        r.kind = cmd;
        r.fault = 1'b0;
        v = '0;
        if (cmd == CMD_TEMP) begin
            x1 = asr(({16'd0, raw[15:0]} - ac6) * ac5, 15);
            num = mc << 11;
            den = x1 + md;
            if (den == 0) begin
                r.fault = 1'b1;
            end else begin
                q = longint'($signed(num)) / longint'($signed(den));
                b5 = x1 + q[31:0];
                b5_held = b5;
                v = clamp(asr(b5 + 32'd8, 4), 32767);
            end
        end else begin
            up = {8'd0, raw} >> (8 - oss_sel);
            b6 = b5_held - 32'd4000;
            b12 = asr(b6 * b6, 12);
            x1 = asr(b12 * b2, 11);
            x2 = asr(ac2 * b6, 11);
            b3 = ((ac1 << 2) + x1 + x2) << oss_sel;
            b3 = asr(b3 + 32'd2, 2);
            x1 = asr(ac3 * b6, 13);
            x2 = asr(b12 * b1, 16);
            x3 = asr(x1 + x2 + 32'd2, 2);
            b4 = ((x3 + 32'd32768) * ac4) >> 15;
            b7 = (up - b3) * (32'd50000 >> oss_sel);
            if (b4 == 0) begin
                r.fault = 1'b1;
            end else begin
                if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
                else p = (b7 / b4) * 32'd2;
                x1 = asr(p, 8);
                x1 = x1 * x1;
                x1 = asr(x1 * 32'd3038, 16);
                x2 = asr((32'd0 - 32'd7357) * p, 16);
                p = p + asr(x1 + x2 + 32'd3791, 4);
                v = clamp(p, 262143);
            end
            b5_held = '0;
        end
        r.value = v[ValW-1:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CAL_A: cal_a = data;
            REG_CAL_B: cal_b = data;
            REG_CAL_C: cal_c = data[31:0];
            REG_OSS:   oss_sel = data[1:0];
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [63:0] a, input logic [63:0] b,
                            input logic [31:0] c, input logic [1:0] oss);
        write_reg(REG_CAL_A, a);
        write_reg(REG_CAL_B, b);
        write_reg(REG_CAL_C, {32'd0, c});
        write_reg(REG_OSS, {62'd0, oss});
    endtask

    // Drives one beat; valid is only lowered when a gap follows.
    task automatic send_sample(input logic cmd, input logic [RawW-1:0] raw);
        int gap;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_raw_sample <= raw;
        do @(posedge aclk); while (!(s_valid && s_ready));
        readings_due.push_back(compensate(cmd, raw));
        if (steady) gap = 0;
        else if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 80);
        else gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 3);
        end
    end

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (readings_due.size() == 0) begin
                report("unexpected beat", {31'd0, m_kind}, 32'd0);
            end else begin
                want = readings_due.pop_front();
                if (m_kind !== want.kind)
                    report("kind", {31'd0, m_kind}, {31'd0, want.kind});
                if (m_value !== want.value)
                    report("value", {13'd0, m_value}, {13'd0, want.value});
                if (m_div_fault !== want.fault)
                    report("div_fault", {31'd0, m_div_fault}, {31'd0, want.fault});
            end
        end
    end

    localparam logic [63:0] TYP_A = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
    localparam logic [63:0] TYP_B = {16'd2868, 16'hDDF9, 16'd23153, 16'd32757};
    localparam logic [31:0] TYP_C = {16'd4, 16'd6190};

    // Zero calibration after reset makes both divisors zero.
    task automatic test_zero_divisors;
        send_sample(CMD_TEMP, 24'd27898);
        send_sample(CMD_PRES, 24'h5D2300);
        drain();
    endtask

    task automatic test_typical;
        int o;
        for (o = 0; o < 4; o++) begin
            write_reg(REG_OSS, {62'd0, 2'(o)});
            send_sample(CMD_TEMP, 24'd27898);
            send_sample(CMD_PRES, 24'h5D2300);
            send_sample(CMD_PRES, 24'hFFFFFF);    // no temperature in front
            send_sample(CMD_TEMP, 24'hFF0000);    // upper byte ignored
            send_sample(CMD_PRES, 24'h000000);
            drain();
        end
        send_sample(CMD_TEMP, 24'hFFFFFF);
        drain();
    endtask

    task automatic test_extremes;
        load_cal('1, '1, '1, 2'd3);
        send_sample(CMD_TEMP, 24'h00FFFF);
        send_sample(CMD_PRES, 24'hFFFFFF);
        drain();
        load_cal({4{16'h8000}}, {16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF},
                 {16'h7FFF, 16'h8000}, 2'd0);
        send_sample(CMD_TEMP, 24'h000000);
        send_sample(CMD_PRES, 24'hFFFFFF);
        send_sample(CMD_TEMP, 24'h00FFFF);
        send_sample(CMD_PRES, 24'h000001);
        drain();
    endtask

    task automatic test_random(input int phases, input int per_phase);
        int ph, n;
        logic [63:0] a, b;
        logic [31:0] c;
        for (ph = 0; ph < phases; ph++) begin
            if (ph % 3 == 2) begin
                a = {$urandom, $urandom}; b = {$urandom, $urandom}; c = $urandom;
            end else begin
                a = TYP_A ^ {4{8'd0, 8'($urandom)}};
                b = TYP_B ^ {4{8'd0, 8'($urandom)}};
                c = TYP_C ^ {2{8'd0, 8'($urandom)}};
            end
            load_cal(a, b, c, ph[1:0]);
            steady = (ph == 1);
            n = 0;
            while (n < per_phase) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_sample(CMD_TEMP, {8'($urandom), 16'($urandom_range(20000, 35000))});
                    send_sample(CMD_PRES, {16'($urandom_range(20000, 45000)), 8'($urandom)});
                    n += 2;
                end else begin
                    send_sample(1'($urandom), 24'($urandom));
                    n++;
                end
            end
            drain();
            steady = 1'b0;
        end
    endtask

    initial begin
        cal_a = '0; cal_b = '0; cal_c = '0; oss_sel = '0; b5_held = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_divisors();
        load_cal(TYP_A, TYP_B, TYP_C, 2'd0);
        test_typical();
        test_extremes();
        test_random(6, 140);
        if (errors == 0 && readings_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/baro_pkg.sv
design/baro_temp_pressure_compensation.sv
verif/tb_top.sv
